// ===== rtl/rtsp_pkg.sv =====
package rtsp_pkg;

    // Default parameter values and the fixed widths of the block.
    localparam int SampleW       = 12;
    localparam int PosW          = 13;
    localparam int DivW          = 25;
    localparam int CfgIdxW       = 3;
    localparam int CfgDataW      = 13;
    localparam int DefSamples    = 5;
    localparam int DefDrop       = 1;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] REG_CAL_LEFT      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_CAL_RIGHT     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_CAL_TOP       = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CAL_BOTTOM    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_MAX_SPREAD    = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_PRESS_TICKS   = 3'd7;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PEN_UP   = 2'd1;
    localparam logic [1:0] ST_DEBOUNCE = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    // Touch phase codes.
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_TOUCH    = 2'd1;
    localparam logic [1:0] PH_RELEASED = 2'd2;

    // Calibration settings used by the datapath.
    typedef struct packed {
        logic [SampleW-1:0] cal_left;
        logic [SampleW-1:0] cal_right;
        logic [SampleW-1:0] cal_top;
        logic [SampleW-1:0] cal_bottom;
        logic [PosW-1:0]    screen_width;
        logic [PosW-1:0]    screen_height;
        logic [SampleW-1:0] max_spread;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       ins;
        logic       acc;
        logic       acc_first;
        logic       mean_store;
        logic       med_store;
        logic [1:0] gi;
        logic       xdiv_start;
        logic       x_store;
        logic       ydiv_start;
        logic       y_store;
        logic       first_cap;
        logic       last_cap;
        logic       out_load;
        logic [1:0] out_status;
        logic [1:0] phase;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic spread_bad;
    } sts_t;

endpackage

// ===== rtl/resistive_touch_sample_processor.sv =====
// Resistive touch sample processor. Pen ticks (tuser 0) and converter frames (tuser 1)
// arrive on the slave stream; a pen-up tick or a tick still in debounce gives a result
// through the emit state, which loads the output register once it is free; any other
// tick gives none. A frame inside a scan is inserted into a sorted group buffer as it
// is accepted; the last frame of a group then leads through the summing state over
// the kept samples and a state that scales the sum into the mean (only a state that
// stores the median when trimming keeps only the median). After the fourth group come
// the spread check and the two axis mappings, each in the bit-serial divider, before
// the point is presented. The output register holds one result, so the next request
// is taken while a result waits.
module resistive_touch_sample_processor #(
    parameter int SAMPLES_PER_GROUP = rtsp_pkg::DefSamples,
    parameter int DROP_EACH_END     = rtsp_pkg::DefDrop
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rtsp_pkg::CfgIdxW-1:0]   cfg_addr,
    input  logic [rtsp_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,  // pen_active, raw_frame, zero pad
    input  logic                           s_tuser,  // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [79:0]                    m_tdata,  // x_pos, y_pos, touch_phase,
                                                     // first_x, first_y, last_x, last_y
    output logic [1:0]                     m_tuser   // status
);

    rtsp_pkg::cfg_t cfg_reg;
    logic [7:0]     press_ticks_reg;
    rtsp_pkg::cmd_t cmd;
    rtsp_pkg::sts_t sts;
    logic [$clog2(SAMPLES_PER_GROUP+1)-1:0] fill;
    logic [$clog2(SAMPLES_PER_GROUP)-1:0]   acc_idx;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_left      <= '0;
            cfg_reg.cal_right     <= 12'd4095;
            cfg_reg.cal_top       <= '0;
            cfg_reg.cal_bottom    <= 12'd4095;
            cfg_reg.screen_width  <= 13'd320;
            cfg_reg.screen_height <= 13'd240;
            cfg_reg.max_spread    <= 12'd50;
            press_ticks_reg       <= 8'd20;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                rtsp_pkg::REG_CAL_LEFT:      cfg_reg.cal_left      <= cfg_data[11:0];
                rtsp_pkg::REG_CAL_RIGHT:     cfg_reg.cal_right     <= cfg_data[11:0];
                rtsp_pkg::REG_CAL_TOP:       cfg_reg.cal_top       <= cfg_data[11:0];
                rtsp_pkg::REG_CAL_BOTTOM:    cfg_reg.cal_bottom    <= cfg_data[11:0];
                rtsp_pkg::REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data;
                rtsp_pkg::REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data;
                rtsp_pkg::REG_MAX_SPREAD:    cfg_reg.max_spread    <= cfg_data[11:0];
                rtsp_pkg::REG_PRESS_TICKS:   press_ticks_reg       <= cfg_data[7:0];
                default:                     press_ticks_reg       <= press_ticks_reg;
            endcase
        end
    end

    rtsp_ctrl #(
        .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
        .DROP_EACH_END     (DROP_EACH_END)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .press_ticks (press_ticks_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_pen      (s_tdata[0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .sts         (sts),
        .cmd         (cmd),
        .fill        (fill),
        .acc_idx     (acc_idx)
    );

    rtsp_dp #(
        .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
        .DROP_EACH_END     (DROP_EACH_END)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .fill       (fill),
        .acc_idx    (acc_idx),
        .raw_frame  (s_tdata[16:1]),
        .sts        (sts),
        .out_status (m_tuser),
        .out_data   (m_tdata)
    );

    // A pen-up tick always leads to a result, so the input closes behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser && !s_tdata[0] |=> !s_tready)
        else $error("input stayed open after a pen-up tick");

    // Loading the output register presents a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("result load did not raise valid");

    // The shared divider is started for one job at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.xdiv_start, cmd.ydiv_start}))
        else $error("divider started for two jobs at once");

    // The divider reports completion only while the block waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> !s_tready)
        else $error("divider finished while the block was idle");

endmodule

// ===== rtl/rtsp_div.sv =====
module rtsp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rtsp_pkg::DivW-1:0]     dividend,
    input  logic [rtsp_pkg::SampleW-1:0]  divisor,
    output logic                          done,
    output logic [rtsp_pkg::DivW-1:0]     quotient
);

    localparam int CntW = $clog2(rtsp_pkg::DivW + 1);

    logic                         busy_reg, busy_next;
    logic [CntW-1:0]              cnt_reg, cnt_next;
    logic [rtsp_pkg::DivW-1:0]    quo_reg, quo_next;
    logic [rtsp_pkg::SampleW-1:0] rem_reg, rem_next;
    logic [rtsp_pkg::SampleW-1:0] dsr_reg, dsr_next;
    logic                         done_reg, done_next;
    logic [rtsp_pkg::SampleW:0]   trial;
    logic                         fits;

    // One quotient bit per cycle, restoring form.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[rtsp_pkg::DivW-1]};
        fits      = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CntW'(rtsp_pkg::DivW);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rtsp_pkg::SampleW'(trial - {1'b0, dsr_reg})
                            : trial[rtsp_pkg::SampleW-1:0];
            quo_next = {quo_reg[rtsp_pkg::DivW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/rtsp_dp.sv =====
module rtsp_dp #(
    parameter int SAMPLES_PER_GROUP = rtsp_pkg::DefSamples,
    parameter int DROP_EACH_END     = rtsp_pkg::DefDrop
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rtsp_pkg::cfg_t                       cfg,
    input  rtsp_pkg::cmd_t                       cmd,
    input  logic [$clog2(SAMPLES_PER_GROUP+1)-1:0] fill,
    input  logic [$clog2(SAMPLES_PER_GROUP)-1:0] acc_idx,
    input  logic [15:0]                          raw_frame,
    output rtsp_pkg::sts_t                       sts,
    output logic [1:0]                           out_status,
    output logic [79:0]                          out_data
);

    localparam int N    = SAMPLES_PER_GROUP;
    localparam int SW   = rtsp_pkg::SampleW;
    localparam int PW   = rtsp_pkg::PosW;
    localparam int DW   = rtsp_pkg::DivW;
    localparam int FW   = $clog2(N + 1);
    localparam int AccW = SW + $clog2(N + 1);
    localparam int Keep = (2 * DROP_EACH_END >= N) ? 1 : N - 2 * DROP_EACH_END;
    localparam int Mid  = (N - 1) / 2;

    // Division of the kept sum by Keep as a multiplication by a rounded-up
    // reciprocal; the shift is wide enough to be exact over every possible sum.
    localparam int RecS = AccW + $clog2(Keep);
    localparam int MW   = AccW + 2;
    localparam int PrW  = AccW + MW;
    localparam logic [MW-1:0] RecM = MW'(((longint'(1) << RecS) + Keep - 1) / Keep);

    logic [SW-1:0] buf_reg [N];
    logic [SW-1:0] buf_next [N];
    logic [SW-1:0] mean_reg [4];
    logic [AccW-1:0] acc_reg, acc_next;
    logic [PW-1:0] x_tmp_reg, now_x_reg, now_y_reg;
    logic [PW-1:0] first_x_reg, first_y_reg, last_x_reg, last_y_reg;
    logic          zero_reg, zero_next;
    logic [PW-1:0] size_reg;
    logic [1:0]    ostat_reg;
    logic [79:0]   odata_reg;

    logic [SW-1:0] sample;
    logic [N-1:0]  le;
    logic [SW:0]   xsum, ysum;
    logic [SW-1:0] ad, lo, hi;
    logic [PW-1:0] size;
    logic [DW-1:0] product;
    logic          div_start, div_done;
    logic [DW-1:0] quo;
    logic [SW-1:0] div_b;
    logic [PW-1:0] mapped;
    logic [SW-1:0] d02, d13;
    logic [PrW-1:0] scaled;

    // Sorted insertion of a new sample into the first fill entries.
    always_comb
    begin
        sample = raw_frame[14:3];
        for (int i = 0; i < N; i++)
        begin
            le[i] = (FW'(i) < fill) && (buf_reg[i] <= sample);
        end
        for (int i = 0; i < N; i++)
        begin
            if (le[i])
                buf_next[i] = buf_reg[i];
            else if (i == 0)
                buf_next[i] = sample;
            else if (le[i-1])
                buf_next[i] = sample;
            else
                buf_next[i] = buf_reg[i-1];
        end
    end

    // Running sum over the kept samples.
    assign acc_next = (cmd.acc_first ? '0 : acc_reg) + AccW'(buf_reg[acc_idx]);

    // Mean of the kept samples.
    assign scaled = PrW'(acc_reg) * PrW'(RecM);

    // Axis averages and the mapping numerator.
    always_comb
    begin
        xsum = {1'b0, mean_reg[0]} + {1'b0, mean_reg[2]};
        ysum = {1'b0, mean_reg[1]} + {1'b0, mean_reg[3]};
        if (cmd.ydiv_start)
        begin
            ad   = ysum[SW:1];
            lo   = cfg.cal_top;
            hi   = cfg.cal_bottom;
            size = cfg.screen_height;
        end
        else
        begin
            ad   = xsum[SW:1];
            lo   = cfg.cal_left;
            hi   = cfg.cal_right;
            size = cfg.screen_width;
        end
        zero_next = (ad <= lo) || (hi <= lo) || (size == '0);
        product   = DW'(ad - lo) * DW'(size - 1'b1);
        div_start = cmd.xdiv_start || cmd.ydiv_start;
        div_b     = hi - lo;
    end

    rtsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (quo)
    );

    // Quotient with the out-of-range cases forced to zero.
    assign mapped = (zero_reg || quo == '0 || quo > DW'(size_reg)) ? '0 : quo[PW-1:0];

    // Spread check between the two readings of each axis.
    always_comb
    begin
        d02 = (mean_reg[0] > mean_reg[2]) ? mean_reg[0] - mean_reg[2] : mean_reg[2] - mean_reg[0];
        d13 = (mean_reg[1] > mean_reg[3]) ? mean_reg[1] - mean_reg[3] : mean_reg[3] - mean_reg[1];
        sts.spread_bad = (d02 > cfg.max_spread) || (d13 > cfg.max_spread);
        sts.div_done   = div_done;
    end

    // Sample, mean, mapping and output storage, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.ins)
            for (int i = 0; i < N; i++)
                buf_reg[i] <= buf_next[i];
        if (cmd.acc)
            acc_reg <= acc_next;
        if (cmd.mean_store)
            mean_reg[cmd.gi] <= scaled[RecS +: SW];
        if (cmd.med_store)
            mean_reg[cmd.gi] <= buf_reg[Mid];
        if (cmd.xdiv_start || cmd.ydiv_start)
        begin
            zero_reg <= zero_next;
            size_reg <= size;
        end
        if (cmd.x_store)
            x_tmp_reg <= mapped;
        if (cmd.out_load)
        begin
            ostat_reg <= cmd.out_status;
            odata_reg <= {last_y_reg, last_x_reg, first_y_reg, first_x_reg, cmd.phase,
                          (cmd.out_status == rtsp_pkg::ST_OK) ? now_y_reg : {PW{1'b0}},
                          (cmd.out_status == rtsp_pkg::ST_OK) ? now_x_reg : {PW{1'b0}}};
        end
    end

    // Points of the touch.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_x_reg   <= '0;
            now_y_reg   <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
        end
        else
        begin
            if (cmd.y_store)
            begin
                now_x_reg <= x_tmp_reg;
                now_y_reg <= mapped;
                if (cmd.first_cap)
                begin
                    first_x_reg <= x_tmp_reg;
                    first_y_reg <= mapped;
                end
            end
            if (cmd.last_cap)
            begin
                last_x_reg <= now_x_reg;
                last_y_reg <= now_y_reg;
            end
        end
    end

    assign out_status = ostat_reg;
    assign out_data   = odata_reg;

endmodule

// ===== rtl/rtsp_ctrl.sv =====
module rtsp_ctrl #(
    parameter int SAMPLES_PER_GROUP = rtsp_pkg::DefSamples,
    parameter int DROP_EACH_END     = rtsp_pkg::DefDrop
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [7:0]                             press_ticks,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   in_op,
    input  logic                                   in_pen,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    input  rtsp_pkg::sts_t                         sts,
    output rtsp_pkg::cmd_t                         cmd,
    output logic [$clog2(SAMPLES_PER_GROUP+1)-1:0] fill,
    output logic [$clog2(SAMPLES_PER_GROUP)-1:0]   acc_idx
);

    localparam int  N     = SAMPLES_PER_GROUP;
    localparam int  FW    = $clog2(N + 1);
    localparam int  IW    = $clog2(N);
    localparam bit  Heavy = (2 * DROP_EACH_END >= N);
    localparam int  First = Heavy ? 0 : DROP_EACH_END;
    localparam int  Last  = Heavy ? 0 : N - DROP_EACH_END - 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_MDIV  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_XDIV  = 3'd4;
    localparam logic [2:0] S_YDIV  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [7:0]    pc_reg, pc_next;
    logic [1:0]    phase_reg, phase_next;
    logic          acq_reg, acq_next;
    logic          fdue_reg, fdue_next;
    logic [1:0]    gi_reg, gi_next;
    logic [FW-1:0] si_reg, si_next;
    logic [IW-1:0] k_reg, k_next;
    logic          oval_reg, oval_next;
    logic [1:0]    stat_reg, stat_next;
    logic [7:0]    pc_inc;
    logic          accept;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        acq_next   = acq_reg;
        fdue_next  = fdue_reg;
        gi_next    = gi_reg;
        si_next    = si_reg;
        k_next     = k_reg;
        stat_next  = stat_reg;
        oval_next  = oval_reg && !out_ready;
        cmd        = '0;
        cmd.gi     = gi_reg;
        cmd.phase  = phase_reg;
        cmd.out_status = stat_reg;
        cmd.first_cap  = fdue_reg;
        pc_inc     = (pc_reg == 8'd255) ? pc_reg : pc_reg + 8'd1;
        accept     = in_valid && (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (accept && !in_op && !in_pen)
                begin
                    // Pen lifted: abort any scan and report pen up.
                    pc_next  = '0;
                    acq_next = 1'b0;
                    fdue_next = 1'b0;
                    gi_next  = '0;
                    si_next  = '0;
                    if (phase_reg == rtsp_pkg::PH_TOUCH)
                    begin
                        phase_next   = rtsp_pkg::PH_RELEASED;
                        cmd.last_cap = 1'b1;
                    end
                    stat_next  = rtsp_pkg::ST_PEN_UP;
                    state_next = S_EMIT;
                end
                else if (accept && !in_op)
                begin
                    pc_next = pc_inc;
                    if (pc_inc >= press_ticks || phase_reg == rtsp_pkg::PH_TOUCH)
                    begin
                        phase_next = rtsp_pkg::PH_TOUCH;
                        if (!acq_reg)
                        begin
                            acq_next  = 1'b1;
                            gi_next   = '0;
                            si_next   = '0;
                            fdue_next = (pc_inc == press_ticks);
                        end
                    end
                    else
                    begin
                        stat_next  = rtsp_pkg::ST_DEBOUNCE;
                        state_next = S_EMIT;
                    end
                end
                else if (accept && acq_reg)
                begin
                    // Converter frame while a scan runs.
                    cmd.ins = 1'b1;
                    if (si_reg == FW'(N - 1))
                    begin
                        si_next    = '0;
                        k_next     = IW'(First);
                        state_next = S_SUM;
                    end
                    else
                    begin
                        si_next = si_reg + 1'b1;
                    end
                end
            end
            S_SUM:
            begin
                if (Heavy)
                begin
                    cmd.med_store = 1'b1;
                    gi_next    = gi_reg + 1'b1;
                    state_next = (gi_reg == 2'd3) ? S_CHECK : S_IDLE;
                end
                else
                begin
                    cmd.acc       = 1'b1;
                    cmd.acc_first = (k_reg == IW'(First));
                    k_next        = k_reg + 1'b1;
                    if (k_reg == IW'(Last))
                    begin
                        state_next = S_MDIV;
                    end
                end
            end
            S_MDIV:
            begin
                // The sum is complete; store its scaled mean.
                cmd.mean_store = 1'b1;
                gi_next    = gi_reg + 1'b1;
                state_next = (gi_reg == 2'd3) ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                if (sts.spread_bad)
                begin
                    acq_next   = 1'b0;
                    fdue_next  = 1'b0;
                    gi_next    = '0;
                    stat_next  = rtsp_pkg::ST_BAD;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.xdiv_start = 1'b1;
                    state_next     = S_XDIV;
                end
            end
            S_XDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.x_store    = 1'b1;
                    cmd.ydiv_start = 1'b1;
                    state_next     = S_YDIV;
                end
            end
            S_YDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.y_store = 1'b1;
                    acq_next    = 1'b0;
                    fdue_next   = 1'b0;
                    gi_next     = '0;
                    stat_next   = rtsp_pkg::ST_OK;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!oval_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    oval_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            phase_reg <= rtsp_pkg::PH_IDLE;
            acq_reg   <= 1'b0;
            fdue_reg  <= 1'b0;
            gi_reg    <= '0;
            si_reg    <= '0;
            k_reg     <= '0;
            oval_reg  <= 1'b0;
            stat_reg  <= rtsp_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            phase_reg <= phase_next;
            acq_reg   <= acq_next;
            fdue_reg  <= fdue_next;
            gi_reg    <= gi_next;
            si_reg    <= si_next;
            k_reg     <= k_next;
            oval_reg  <= oval_next;
            stat_reg  <= stat_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = oval_reg;
    assign fill      = si_reg;
    assign acc_idx   = k_reg;

endmodule

// ===== dv/resistive_touch_sample_processor_test.sv =====
module resistive_touch_sample_processor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rtsp_pkg::*;

    localparam int NSAMP = DefSamples;
    localparam int NDROP = DefDrop;

    // One expected touch report.
    typedef struct {
        logic [1:0]  status;
        logic [12:0] x_pos;
        logic [12:0] y_pos;
        logic [1:0]  touch_phase;
        logic [12:0] first_x;
        logic [12:0] first_y;
        logic [12:0] last_x;
        logic [12:0] last_y;
    } report_t;

    // One row of the directed stimulus table.
    typedef struct {
        logic        op;
        logic        pen;
        logic [15:0] raw;
        bit          typed;
        logic [1:0]  t_status;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    resistive_touch_sample_processor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predictor copy of the calibration registers.
    logic [11:0] p_left, p_right, p_top, p_bottom, p_spread;
    logic [12:0] p_width, p_height;
    logic [7:0]  p_ticks;

    // Predictor copy of the touch state.
    logic [7:0]  pen_count;
    logic [1:0]  pen_phase;
    bit          scanning;
    bit          capture_first;
    int          grp;
    int          smp;
    logic [11:0] samples [NSAMP];
    logic [11:0] means [4];
    logic [12:0] cur_pt [2];
    logic [12:0] first_pt [2];
    logic [12:0] last_pt [2];

    report_t reports_due[$];
    int      failures;
    int      items_sent;
    bit      idle_on;
    int      stall_left;
    int      hold_left;
    bit      hold_done;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Timeout guard.
    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [11:0] group_value();
        logic [11:0] s [NSAMP];
        logic [11:0] t;
        int          acc;
        acc = 0;
        for (int i = 0; i < NSAMP; i++)
            s[i] = samples[i];
        for (int i = 0; i + 1 < NSAMP; i++)
            for (int j = i + 1; j < NSAMP; j++)
                if (s[i] > s[j])
                begin
                    t = s[i];
                    s[i] = s[j];
                    s[j] = t;
                end
        if (2 * NDROP >= NSAMP)
            return s[(NSAMP - 1) / 2];
        for (int i = NDROP; i < NSAMP - NDROP; i++)
            acc += s[i];
        return 12'(acc / (NSAMP - 2 * NDROP));
    endfunction

    function automatic logic [12:0] to_pixel(int ad, int lo, int hi, int size);
        int q;
        if (ad <= lo || hi <= lo || size == 0)
            return 13'd0;
        q = (ad - lo) * (size - 1) / (hi - lo);
        if (q == 0 || q > size)
            return 13'd0;
        return 13'(q);
    endfunction

    function automatic int gap(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void end_scan();
        scanning = 0;
        capture_first = 0;
        grp = 0;
        smp = 0;
    endfunction

    function automatic void queue_report(logic [1:0] st, logic [12:0] x, logic [12:0] y);
        report_t r;
        r.status = st;
        r.x_pos = x;
        r.y_pos = y;
        r.touch_phase = pen_phase;
        r.first_x = first_pt[0];
        r.first_y = first_pt[1];
        r.last_x = last_pt[0];
        r.last_y = last_pt[1];
        reports_due.push_back(r);
    endfunction

    // Advance the touch state by one accepted request; queue any report.
    function automatic void track_touch(logic op, logic pen, logic [15:0] raw);
        logic [12:0] x, y;
        if (!op)
        begin
            if (!pen)
            begin
                pen_count = 8'd0;
                end_scan();
                if (pen_phase == PH_TOUCH)
                begin
                    pen_phase = PH_RELEASED;
                    last_pt[0] = cur_pt[0];
                    last_pt[1] = cur_pt[1];
                end
                queue_report(ST_PEN_UP, 13'd0, 13'd0);
                return;
            end
            if (pen_count != 8'd255)
                pen_count++;
            if (pen_count >= p_ticks || pen_phase == PH_TOUCH)
            begin
                pen_phase = PH_TOUCH;
                if (!scanning)
                begin
                    scanning = 1;
                    grp = 0;
                    smp = 0;
                    capture_first = (pen_count == p_ticks);
                end
                return;
            end
            queue_report(ST_DEBOUNCE, 13'd0, 13'd0);
            return;
        end
        if (!scanning)
            return;
        samples[smp] = raw[14:3];
        smp++;
        if (smp < NSAMP)
            return;
        smp = 0;
        means[grp] = group_value();
        grp++;
        if (grp < 4)
            return;
        if (gap(means[0], means[2]) > p_spread || gap(means[1], means[3]) > p_spread)
        begin
            end_scan();
            queue_report(ST_BAD, 13'd0, 13'd0);
            return;
        end
        x = to_pixel((int'(means[0]) + int'(means[2])) / 2, p_left, p_right, p_width);
        y = to_pixel((int'(means[1]) + int'(means[3])) / 2, p_top, p_bottom, p_height);
        cur_pt[0] = x;
        cur_pt[1] = y;
        if (capture_first)
        begin
            first_pt[0] = x;
            first_pt[1] = y;
        end
        end_scan();
        queue_report(ST_OK, x, y);
    endfunction

    // Offer one request, with an occasional gap before it.
    task automatic send_request(logic op, logic pen, logic [15:0] raw);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'd0, raw, pen};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_touch(op, pen, raw);
        items_sent++;
        idle_on = (items_sent < 480);
    endtask

    // Stop sending and let every pending report arrive and the block settle.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [12:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_CAL_LEFT:      p_left = val[11:0];
            REG_CAL_RIGHT:     p_right = val[11:0];
            REG_CAL_TOP:       p_top = val[11:0];
            REG_CAL_BOTTOM:    p_bottom = val[11:0];
            REG_SCREEN_WIDTH:  p_width = val;
            REG_SCREEN_HEIGHT: p_height = val;
            REG_MAX_SPREAD:    p_spread = val[11:0];
            default:           p_ticks = val[7:0];
        endcase
    endtask

    function automatic logic [15:0] frame_of(int v);
        logic [11:0] s;
        s = (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : 12'(v);
        return {1'($urandom_range(0, 1)), s, 3'($urandom_range(0, 7))};
    endfunction

    // One press: debounce, one to three scans, then release; some presses end early.
    task automatic run_touch();
        int n_ticks, n_scans, bx, by, base, d;
        send_request(1'b0, 1'b0, 16'($urandom));
        if ($urandom_range(0, 7) == 0)
            send_request(1'b1, 1'b0, 16'($urandom));
        n_ticks = (p_ticks == 0) ? 1 : int'(p_ticks);
        if ($urandom_range(0, 9) == 0)
            n_ticks = $urandom_range(0, n_ticks - 1);
        else
            n_ticks += $urandom_range(0, 1);
        for (int i = 0; i < n_ticks; i++)
            send_request(1'b0, 1'b1, 16'($urandom));
        if (n_ticks == 0 || (p_ticks != 0 && n_ticks < p_ticks))
        begin
            send_request(1'b0, 1'b0, 16'($urandom));
            return;
        end
        n_scans = $urandom_range(1, 3);
        for (int k = 0; k < n_scans; k++)
        begin
            if (k > 0)
                send_request(1'b0, 1'b1, 16'($urandom));
            bx = $urandom_range(0, 4095);
            by = $urandom_range(0, 4095);
            d = int'(p_spread) + 20;
            for (int g = 0; g < 4; g++)
            begin
                base = (g % 2 == 0) ? bx : by;
                if (g >= 2)
                    base += $urandom_range(0, 2 * d) - d;
                for (int s = 0; s < NSAMP; s++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_request(1'b0, 1'b1, 16'($urandom));
                    if ($urandom_range(0, 79) == 0)
                    begin
                        send_request(1'b0, 1'b0, 16'($urandom));
                        return;
                    end
                    if ($urandom_range(0, 19) == 0)
                        send_request(1'b1, 1'($urandom), 16'($urandom));
                    else
                        send_request(1'b1, 1'($urandom),
                                     frame_of(base + $urandom_range(0, 8)));
                end
            end
        end
        send_request(1'b0, 1'b0, 16'($urandom));
    endtask

    // Result checking and output-side backpressure.
    always @(posedge clk)
    begin
        report_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("unexpected report, status %0d", m_tuser);
                failures++;
            end
            else
            begin
                e = reports_due.pop_front();
                if (m_tuser !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, m_tuser);
                    failures++;
                end
                if (m_tdata[12:0] !== e.x_pos)
                begin
                    $error("x_pos: expected %0d, got %0d", e.x_pos, m_tdata[12:0]);
                    failures++;
                end
                if (m_tdata[25:13] !== e.y_pos)
                begin
                    $error("y_pos: expected %0d, got %0d", e.y_pos, m_tdata[25:13]);
                    failures++;
                end
                if (m_tdata[27:26] !== e.touch_phase)
                begin
                    $error("touch_phase: expected %0d, got %0d", e.touch_phase,
                           m_tdata[27:26]);
                    failures++;
                end
                if (m_tdata[40:28] !== e.first_x)
                begin
                    $error("first_x: expected %0d, got %0d", e.first_x, m_tdata[40:28]);
                    failures++;
                end
                if (m_tdata[53:41] !== e.first_y)
                begin
                    $error("first_y: expected %0d, got %0d", e.first_y, m_tdata[53:41]);
                    failures++;
                end
                if (m_tdata[66:54] !== e.last_x)
                begin
                    $error("last_x: expected %0d, got %0d", e.last_x, m_tdata[66:54]);
                    failures++;
                end
                if (m_tdata[79:67] !== e.last_y)
                begin
                    $error("last_y: expected %0d, got %0d", e.last_y, m_tdata[79:67]);
                    failures++;
                end
            end
        end
        // One long hold so the block backs up into its input.
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && items_sent >= 200)
        begin
            hold_done = 1;
            hold_left = 400;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Main stimulus sequence.
    initial
    begin
        stim_row_t   rows[$];
        stim_row_t   r;
        int          pno;
        int          start_cnt;
        logic [11:0] a, b;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        failures = 0;
        items_sent = 0;
        idle_on = 1;
        stall_left = 0;
        hold_left = 0;
        hold_done = 0;
        p_left = 12'd0;
        p_right = 12'd4095;
        p_top = 12'd0;
        p_bottom = 12'd4095;
        p_width = 13'd320;
        p_height = 13'd240;
        p_spread = 12'd50;
        p_ticks = 8'd20;
        pen_count = 8'd0;
        pen_phase = PH_IDLE;
        end_scan();
        for (int i = 0; i < 2; i++)
        begin
            cur_pt[i] = 13'd0;
            first_pt[i] = 13'd0;
            last_pt[i] = 13'd0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_PRESS_TICKS, 13'd2);
        cfg_we <= 1'b0;
        @(posedge clk);

        // Directed table: pen up after reset, debounce, one scan of extreme frames.
        rows.push_back('{1'b0, 1'b0, 16'hFFFF, 1, ST_PEN_UP});
        rows.push_back('{1'b0, 1'b1, 16'h0000, 1, ST_DEBOUNCE});
        rows.push_back('{1'b1, 1'b1, 16'hFFFF, 0, ST_OK});
        rows.push_back('{1'b0, 1'b1, 16'h0000, 0, ST_OK});
        for (int g = 0; g < 4; g++)
        begin
            rows.push_back('{1'b1, 1'b0, 16'hFFFF, 0, ST_OK});
            rows.push_back('{1'b1, 1'b1, 16'h7FF8, 0, ST_OK});
            rows.push_back('{1'b1, 1'b0, 16'h0000, 0, ST_OK});
            rows.push_back('{1'b1, 1'b1, 16'h8007, 0, ST_OK});
            rows.push_back('{1'b1, 1'b0, 16'hFFFF, 0, ST_OK});
        end
        rows.push_back('{1'b0, 1'b0, 16'h0000, 0, ST_OK});
        foreach (rows[i])
        begin
            r = rows[i];
            send_request(r.op, r.pen, r.raw);
            if (r.typed)
            begin
                // After reset every point is still zero.
                reports_due[reports_due.size() - 1] =
                    '{r.t_status, 13'd0, 13'd0, PH_IDLE, 13'd0, 13'd0, 13'd0, 13'd0};
            end
        end

        // Random phases, each with its own calibration.
        pno = 0;
        while (items_sent < 540)
        begin
            drain_reports();
            pno++;
            case (pno)
                1:
                begin
                    write_reg(REG_CAL_LEFT, 13'd0);
                    write_reg(REG_CAL_RIGHT, 13'd4095);
                    write_reg(REG_CAL_TOP, 13'd0);
                    write_reg(REG_CAL_BOTTOM, 13'd4095);
                    write_reg(REG_SCREEN_WIDTH, 13'd4096);
                    write_reg(REG_SCREEN_HEIGHT, 13'd4096);
                    write_reg(REG_MAX_SPREAD, 13'd4095);
                    write_reg(REG_PRESS_TICKS, 13'd1);
                end
                2:
                begin
                    write_reg(REG_SCREEN_WIDTH, 13'd1);
                    write_reg(REG_SCREEN_HEIGHT, 13'd1);
                    write_reg(REG_MAX_SPREAD, 13'd0);
                    write_reg(REG_PRESS_TICKS, 13'd255);
                end
                3:
                begin
                    write_reg(REG_CAL_LEFT, 13'd4095);
                    write_reg(REG_CAL_RIGHT, 13'd0);
                    write_reg(REG_CAL_TOP, 13'd3000);
                    write_reg(REG_CAL_BOTTOM, 13'd3000);
                    write_reg(REG_SCREEN_WIDTH, 13'd800);
                    write_reg(REG_SCREEN_HEIGHT, 13'd600);
                    write_reg(REG_MAX_SPREAD, 13'd100);
                    write_reg(REG_PRESS_TICKS, 13'd0);
                end
                default:
                begin
                    a = 12'($urandom_range(0, 1500));
                    b = 12'($urandom_range(2500, 4095));
                    write_reg(REG_CAL_LEFT, {1'b0, a});
                    write_reg(REG_CAL_RIGHT, {1'b0, b});
                    a = 12'($urandom_range(0, 1500));
                    b = 12'($urandom_range(2500, 4095));
                    write_reg(REG_CAL_TOP, {1'b0, a});
                    write_reg(REG_CAL_BOTTOM, {1'b0, b});
                    write_reg(REG_SCREEN_WIDTH, 13'($urandom_range(1, 4096)));
                    write_reg(REG_SCREEN_HEIGHT, 13'($urandom_range(1, 4096)));
                    write_reg(REG_MAX_SPREAD, 13'($urandom_range(0, 300)));
                    write_reg(REG_PRESS_TICKS, 13'($urandom_range(1, 4)));
                end
            endcase
            cfg_we <= 1'b0;
            @(posedge clk);
            start_cnt = items_sent;
            while (items_sent - start_cnt < 40 && items_sent < 540)
                run_touch();
            // Always leave the phase with the pen up so no scan is open.
            send_request(1'b0, 1'b0, 16'($urandom));
        end

        drain_reports();
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
